// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AR(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	`ASSERT_AR(lbl, clk, rstn, !(expr), msg)

`endif

// ----- rtl/rcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and defaults for the rendezvous channel matcher.
// ----------------------------------------------------------------------------
package rcm_pkg;

	localparam int DEF_WAIT_DEPTH   = 16;
	localparam int DEF_CHANNEL_BITS = 8;
	localparam int DEF_PROC_BITS    = 4;
	localparam int STATUS_BITS      = 2;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_MATCHED  = 2'd0,
		ST_QUEUED   = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	// per-list update command, broadcast to every cell of a row
	typedef struct packed {
		logic take;    // remove oldest matching entry, shift younger ones down
		logic append;  // write request into first free cell
	} rcm_ctl_t;

endpackage

// ----- rtl/rendezvous_channel_matcher_core.sv -----
// ----------------------------------------------------------------------------
// rendezvous_channel_matcher_core
// Pairs send and receive requests on a channel using two packed waiting
// lists built as rows of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  request  in         in_valid / in_stall    operation, channel, requester
//  result   out        out_valid / out_stall  status, partner
//
//  Each request is registered first; then both cell rows compare in parallel,
//  ripple the oldest-hit chain and shift or append.
//  One request in flight at a time; in_stall is high while it is held.
//  A stalled result holds the request in flight and leaves the lists as is.
//  Reset clears both lists at once (used bits only); no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rendezvous_channel_matcher_core #(
	parameter int WAIT_DEPTH   = rcm_pkg::DEF_WAIT_DEPTH,
	parameter int CHANNEL_BITS = rcm_pkg::DEF_CHANNEL_BITS,
	parameter int PROC_BITS    = rcm_pkg::DEF_PROC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [CHANNEL_BITS-1:0]          channel,
	input  logic [PROC_BITS-1:0]             requester,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rcm_pkg::STATUS_BITS-1:0]  status,
	output logic [PROC_BITS-1:0]             partner
);

	logic                    busy_q;
	logic                    op_s1;
	logic [CHANNEL_BITS-1:0] chan_s1;
	logic [PROC_BITS-1:0]    req_s1;

	logic                    out_valid_q;
	rcm_pkg::status_t        status_q;
	logic [PROC_BITS-1:0]    partner_q;

	logic                    in_take;
	logic                    done;
	rcm_pkg::rcm_ctl_t       send_ctl;
	rcm_pkg::rcm_ctl_t       recv_ctl;
	logic                    send_hit;
	logic                    recv_hit;
	logic                    send_full;
	logic                    recv_full;
	logic [PROC_BITS-1:0]    send_partner;
	logic [PROC_BITS-1:0]    recv_partner;
	logic                    hit;
	logic                    own_full;
	rcm_pkg::status_t        status_d;
	logic [PROC_BITS-1:0]    partner_d;

	assign in_stall = busy_q;
	assign in_take  = in_valid && !in_stall;
	assign done     = busy_q && !(out_valid_q && out_stall);

	// op_s1 high = receive request: takes from send list, waits on recv list
	assign send_ctl.take   = done && op_s1;
	assign send_ctl.append = done && !op_s1 && !recv_hit;
	assign recv_ctl.take   = done && !op_s1;
	assign recv_ctl.append = done && op_s1 && !send_hit;

	rcm_list #(
		.WAIT_DEPTH   (WAIT_DEPTH),
		.CHANNEL_BITS (CHANNEL_BITS),
		.PROC_BITS    (PROC_BITS)
	) u_send (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (send_ctl),
		.key     (chan_s1),
		.who     (req_s1),
		.hit     (send_hit),
		.partner (send_partner),
		.full    (send_full)
	);

	rcm_list #(
		.WAIT_DEPTH   (WAIT_DEPTH),
		.CHANNEL_BITS (CHANNEL_BITS),
		.PROC_BITS    (PROC_BITS)
	) u_recv (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (recv_ctl),
		.key     (chan_s1),
		.who     (req_s1),
		.hit     (recv_hit),
		.partner (recv_partner),
		.full    (recv_full)
	);

	assign hit      = op_s1 ? send_hit : recv_hit;
	assign own_full = op_s1 ? recv_full : send_full;

	always_comb begin
		if (hit) begin
			status_d  = rcm_pkg::ST_MATCHED;
			partner_d = op_s1 ? send_partner : recv_partner;
		end else if (own_full) begin
			status_d  = rcm_pkg::ST_REJECTED;
			partner_d = '0;
		end else begin
			status_d  = rcm_pkg::ST_QUEUED;
			partner_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= operation;
			chan_s1 <= channel;
			req_s1  <= requester;
		end
		if (done) begin
			status_q  <= status_d;
			partner_q <= partner_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign partner   = partner_q;

	// a channel never waits on both lists at once
	`ASSERT_NEVER(a_no_dual_wait, clk, arst_n, busy_q && send_hit && recv_hit,
		"channel waiting on both send and receive lists")
	`ASSERT_AR(a_done_delivers, clk, arst_n, done |=> out_valid && !busy_q,
		"finished request did not produce a result")
	`ASSERT_AR(a_take_busy, clk, arst_n, in_take |=> busy_q && !in_stall == 1'b0,
		"accepted request not held in flight")

endmodule

// ----- rtl/rcm_cell.sv -----
// ----------------------------------------------------------------------------
// rcm_cell
// One slot of a waiting list: compares against the request channel, ripples
// the oldest-hit chain and shifts in its younger neighbor on a removal.
// ----------------------------------------------------------------------------
module rcm_cell #(
	parameter int CHANNEL_BITS = rcm_pkg::DEF_CHANNEL_BITS,
	parameter int PROC_BITS    = rcm_pkg::DEF_PROC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcm_pkg::rcm_ctl_t       ctl,
	input  logic [CHANNEL_BITS-1:0] key,
	input  logic [PROC_BITS-1:0]    who,
	// from older neighbor
	input  logic                    prev_used,
	input  logic                    hit_in,
	input  logic [PROC_BITS-1:0]    owner_in,
	// from younger neighbor
	input  logic                    next_used,
	input  logic [CHANNEL_BITS-1:0] next_chan,
	input  logic [PROC_BITS-1:0]    next_owner,
	// to neighbors
	output logic                    used,
	output logic [CHANNEL_BITS-1:0] chan,
	output logic [PROC_BITS-1:0]    owner,
	output logic                    hit_out,
	output logic [PROC_BITS-1:0]    owner_out
);

	logic                    used_q;
	logic [CHANNEL_BITS-1:0] chan_q;
	logic [PROC_BITS-1:0]    owner_q;
	logic                    match;
	logic                    do_shift;
	logic                    do_fill;

	assign match     = used_q && (chan_q == key);
	assign hit_out   = hit_in || match;
	assign owner_out = hit_in ? owner_in : (match ? owner_q : '0);

	// every cell at or after the oldest hit moves down one slot
	assign do_shift = ctl.take && hit_out;
	// packed list: first free slot is the one whose older neighbor is used
	assign do_fill  = ctl.append && !used_q && prev_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (do_shift) begin
			used_q <= next_used;
		end else if (do_fill) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_shift) begin
			chan_q  <= next_chan;
			owner_q <= next_owner;
		end else if (do_fill) begin
			chan_q  <= key;
			owner_q <= who;
		end
	end

	assign used  = used_q;
	assign chan  = chan_q;
	assign owner = owner_q;

endmodule

// ----- rtl/rcm_list.sv -----
// ----------------------------------------------------------------------------
// rcm_list
// A row of cells forming one waiting list, oldest entry in cell 0.
// ----------------------------------------------------------------------------
module rcm_list #(
	parameter int WAIT_DEPTH   = rcm_pkg::DEF_WAIT_DEPTH,
	parameter int CHANNEL_BITS = rcm_pkg::DEF_CHANNEL_BITS,
	parameter int PROC_BITS    = rcm_pkg::DEF_PROC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rcm_pkg::rcm_ctl_t       ctl,
	input  logic [CHANNEL_BITS-1:0] key,
	input  logic [PROC_BITS-1:0]    who,
	output logic                    hit,
	output logic [PROC_BITS-1:0]    partner,
	output logic                    full
);

	// chain taps; index WAIT_DEPTH is the virtual slot past the tail
	logic                    used_c  [WAIT_DEPTH+1];
	logic [CHANNEL_BITS-1:0] chan_c  [WAIT_DEPTH+1];
	logic [PROC_BITS-1:0]    owner_c [WAIT_DEPTH+1];
	logic                    hit_c   [WAIT_DEPTH+1];
	logic [PROC_BITS-1:0]    pown_c  [WAIT_DEPTH+1];

	assign used_c[WAIT_DEPTH]  = 1'b0;
	assign chan_c[WAIT_DEPTH]  = '0;
	assign owner_c[WAIT_DEPTH] = '0;
	assign hit_c[0]            = 1'b0;
	assign pown_c[0]           = '0;

	for (genvar i = 0; i < WAIT_DEPTH; i++) begin : g_cell
		logic prev_used;
		if (i == 0) begin : g_head
			assign prev_used = 1'b1;
		end else begin : g_body
			assign prev_used = used_c[i-1];
		end

		rcm_cell #(
			.CHANNEL_BITS (CHANNEL_BITS),
			.PROC_BITS    (PROC_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key),
			.who        (who),
			.prev_used  (prev_used),
			.hit_in     (hit_c[i]),
			.owner_in   (pown_c[i]),
			.next_used  (used_c[i+1]),
			.next_chan  (chan_c[i+1]),
			.next_owner (owner_c[i+1]),
			.used       (used_c[i]),
			.chan       (chan_c[i]),
			.owner      (owner_c[i]),
			.hit_out    (hit_c[i+1]),
			.owner_out  (pown_c[i+1])
		);
	end

	assign hit     = hit_c[WAIT_DEPTH];
	assign partner = pown_c[WAIT_DEPTH];
	assign full    = used_c[WAIT_DEPTH-1];

endmodule
